@@ sv/rtact_pkg.sv @@
// Shared types and constants of the relative-to-absolute contact tracker.
package rtact_pkg;

  localparam int NUM_CONTACTS_DEF = 2;
  localparam int COORD_MAX_DEF    = 4095;

  localparam logic [15:0] TIMEOUT_RST = 16'd100;

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_MOVE_X = 2'd1;
  localparam logic [1:0] REQ_MOVE_Y = 2'd2;
  localparam logic [1:0] REQ_OTHER = 2'd3;

  // Configuration register indexes
  localparam logic CFG_ENABLE  = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // One report as it travels along the cell chain
  typedef struct packed {
    logic [2:0]  contact;
    logic        active;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } rep_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic       tick;
    logic       add;
    logic       axis_y;
    logic [2:0] index;
    logic       sync;
    logic       load;
    logic       shift;
  } cell_cmd_t;

endpackage

@@ sv/rtact_cell.sv @@
// One contact cell: position, age and live state plus one report stage of the chain.
module rtact_cell #(
  parameter int CELL_ID   = 0,
  parameter int COORD_MAX = rtact_pkg::COORD_MAX_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rtact_pkg::cell_cmd_t    cmd,
  input  logic signed [32:0]      product,
  input  logic [15:0]             timeout,
  input  rtact_pkg::rep_t         rep_in,
  output rtact_pkg::rep_t         rep_out
);
  import rtact_pkg::*;

  localparam logic signed [31:0] COORD_RST = 32'(COORD_MAX / 2);
  localparam logic [15:0]        CMAX      = 16'(COORD_MAX);

  logic signed [31:0] x_r, x_nxt;
  logic signed [31:0] y_r, y_nxt;
  logic [15:0]        age_r, age_nxt;
  logic               live_r, live_nxt;
  rep_t               rep_r, rep_nxt;

  logic               sel;
  logic signed [31:0] base;
  logic signed [33:0] sum;
  logic signed [31:0] sat;
  logic               live_eff;

  function automatic logic [15:0] clamp_pos(input logic signed [31:0] v,
                                            input logic [15:0] cmax);
    logic [15:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({16'd0, cmax})) begin
      r = cmax;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign sel  = cmd.add && (cmd.index == 3'(CELL_ID));
  assign base = cmd.axis_y ? y_r : x_r;
  assign sum  = {{2{base[31]}}, base} + {product[32], product};

  // saturate to the signed 32-bit range
  always_comb begin
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      sat = sum[31:0];
    end else if (sum[33]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7fff_ffff;
    end
  end

  assign live_eff = live_r && !(age_r > timeout);

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    age_nxt  = age_r;
    live_nxt = live_r;
    rep_nxt  = rep_r;
    if (cmd.tick && age_r != 16'hffff) begin
      age_nxt = age_r + 16'd1;
    end
    if (sel) begin
      if (cmd.axis_y) begin
        y_nxt = sat;
      end else begin
        x_nxt = sat;
      end
      if (cmd.sync) begin
        live_nxt = 1'b1;
        age_nxt  = '0;
      end
    end
    if (cmd.load) begin
      live_nxt        = live_eff;
      rep_nxt.contact = 3'(CELL_ID);
      rep_nxt.active  = live_eff;
      rep_nxt.pos_x   = clamp_pos(x_r, CMAX);
      rep_nxt.pos_y   = clamp_pos(y_r, CMAX);
    end else if (cmd.shift) begin
      rep_nxt = rep_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= COORD_RST;
      y_r    <= COORD_RST;
      age_r  <= '0;
      live_r <= 1'b0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      age_r  <= age_nxt;
      live_r <= live_nxt;
    end
    rep_r <= rep_nxt;
  end

  assign rep_out = rep_r;

endmodule

@@ sv/relative_to_absolute_contact_tracker_core.sv @@
// Top level: control sequencer, shared multiplier and the chain of contact cells.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | req_type, contact_index, delta, gain, sync
//  out_    | output    | out_valid/out_stall| kind, handled, report_contact, contact_active,
//          |           |                    | pos_x, pos_y, last
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Tick, other and disabled items: accept, then one result beat.
// Motion: accept with multiply, saturating add in the addressed cell, then a
// result beat; with sync a load replaces the result beat and NUM_CONTACTS report
// beats shift out of the cell chain, one per cycle while out_stall is low.
// One item is in work at a time; in_stall is high until its last beat is taken.
// Output stalls hold the chain and the result; reset leaves all contacts inactive.
module relative_to_absolute_contact_tracker_core #(
  parameter int NUM_CONTACTS = rtact_pkg::NUM_CONTACTS_DEF,
  parameter int COORD_MAX    = rtact_pkg::COORD_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [2:0]  in_contact_index,
  input  logic signed [15:0] in_delta,
  input  logic [15:0] in_gain,
  input  logic        in_sync,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic        out_handled,
  output logic [2:0]  out_report_contact,
  output logic        out_contact_active,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import rtact_pkg::*;

  localparam int CNT_W = (NUM_CONTACTS > 1) ? $clog2(NUM_CONTACTS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_CONTACTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_LOAD,
    S_DISP,
    S_REP
  } state_t;

  state_t             state_r;
  logic               enable_r;
  logic [15:0]        timeout_r;
  logic signed [32:0] product_r;
  logic [2:0]         idx_r;
  logic               axis_y_r;
  logic               sync_r;
  logic               handled_r;
  logic [CNT_W-1:0]   cnt_r;

  logic               in_acc, out_acc;
  logic               is_motion;
  logic [15:0]        gain_eff;
  logic [2:0]         idx_map;
  cell_cmd_t          cmd;
  rep_t               chain [NUM_CONTACTS+1];

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == S_DISP) || (state_r == S_REP);
  assign out_acc   = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  assign is_motion = enable_r && (in_req_type == REQ_MOVE_X || in_req_type == REQ_MOVE_Y);
  assign gain_eff  = (in_gain == '0) ? 16'd1 : in_gain;
  assign idx_map   = ({1'b0, in_contact_index} >= 4'(NUM_CONTACTS)) ?
                     3'(NUM_CONTACTS - 1) : in_contact_index;

  always_comb begin
    cmd        = '0;
    cmd.tick   = in_acc && (in_req_type == REQ_TICK);
    cmd.add    = (state_r == S_ADD);
    cmd.axis_y = axis_y_r;
    cmd.index  = idx_r;
    cmd.sync   = sync_r;
    cmd.load   = (state_r == S_LOAD);
    cmd.shift  = (state_r == S_REP) && out_acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      enable_r  <= 1'b1;
      timeout_r <= TIMEOUT_RST;
      handled_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENABLE:  enable_r  <= cfg_data[0];
          CFG_TIMEOUT: timeout_r <= cfg_data;
          default:     ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (is_motion) begin
              state_r <= S_ADD;
            end else begin
              handled_r <= 1'b0;
              state_r   <= S_DISP;
            end
          end
        end
        S_ADD: begin
          if (sync_r) begin
            state_r <= S_LOAD;
          end else begin
            handled_r <= 1'b1;
            state_r   <= S_DISP;
          end
        end
        S_LOAD: begin
          cnt_r   <= '0;
          state_r <= S_REP;
        end
        S_DISP: begin
          if (out_acc) state_r <= S_IDLE;
        end
        S_REP: begin
          if (out_acc) begin
            if (cnt_r == CNT_LAST) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (in_acc) begin
      product_r <= in_delta * $signed({1'b0, gain_eff});
      idx_r     <= idx_map;
      axis_y_r  <= (in_req_type == REQ_MOVE_Y);
      sync_r    <= in_sync;
    end
  end

  assign chain[NUM_CONTACTS] = '0;

  for (genvar i = 0; i < NUM_CONTACTS; i++) begin : g_cell
    rtact_cell #(
      .CELL_ID   (i),
      .COORD_MAX (COORD_MAX)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .product (product_r),
      .timeout (timeout_r),
      .rep_in  (chain[i+1]),
      .rep_out (chain[i])
    );
  end

  always_comb begin
    out_kind           = 1'b0;
    out_handled        = handled_r;
    out_report_contact = '0;
    out_contact_active = 1'b0;
    out_pos_x          = '0;
    out_pos_y          = '0;
    out_last           = 1'b1;
    if (state_r == S_REP) begin
      out_kind           = 1'b1;
      out_handled        = 1'b1;
      out_report_contact = chain[0].contact;
      out_contact_active = chain[0].active;
      out_pos_x          = chain[0].pos_x;
      out_pos_y          = chain[0].pos_y;
      out_last           = (cnt_r == CNT_LAST);
    end
  end

  // no new item while a result beat is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !out_valid)
    else $error("item accepted while a result is pending");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !out_valid)
    else $error("result beat after last");

  a_report_handled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind) |-> out_handled)
    else $error("report beat not marked handled");

  a_report_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind && out_last) |-> (out_report_contact == 3'(NUM_CONTACTS - 1)))
    else $error("final report is not the last contact");

endmodule
